// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bis_pkg.sv =====
// Constants and types shared by the bank interleave splitter.
package bis_pkg;

   localparam int NUM_BANKS     = 8;
   localparam int BANK_BYTES    = 8;
   localparam int MAX_REQ_BYTES = 256;
   localparam int ADDR_BITS     = 32;

   localparam int WORD_SHIFT = $clog2(BANK_BYTES);
   localparam int BANK_SHIFT = $clog2(NUM_BANKS);
   localparam int TOP_SHIFT  = WORD_SHIFT + BANK_SHIFT;

   localparam int LEN_W   = 9;
   localparam int BANK_W  = 3;
   localparam int BADDR_W = 29;
   localparam int CHUNK_W = 4;
   localparam int DOFF_W  = 8;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_W-1:0]     len;
      logic                 wr;
   } req_entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== rtl/bis_front.sv =====
// Input stage: takes request words, clamps the length and drops empty requests.
module bis_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_start_address,
   input  logic [8:0]              req_request_bytes,
   input  logic                    req_write_flag,
   input  bis_pkg::queue_status_type q_status,
   output logic                    push_valid,
   output bis_pkg::req_entry_type  push_entry
);
   import bis_pkg::*;

   logic          fv_ff, fv_in;
   req_entry_type entry_ff, entry_in;
   logic          accept;
   logic [LEN_W-1:0] clamped_len;

   assign req_ready  = !fv_ff || q_status.not_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = fv_ff;
   assign push_entry = entry_ff;

   always_comb begin
      if (req_request_bytes > LEN_W'(MAX_REQ_BYTES)) begin
         clamped_len = LEN_W'(MAX_REQ_BYTES);
      end else begin
         clamped_len = req_request_bytes;
      end
   end

   always_comb begin
      fv_in    = fv_ff;
      entry_in = entry_ff;
      if (fv_ff && q_status.not_full) begin
         fv_in = 1'b0;
      end
      if (accept) begin
         // A zero-length request produces no chunks, so it is never queued.
         fv_in         = (clamped_len != '0);
         entry_in.addr = req_start_address;
         entry_in.len  = clamped_len;
         entry_in.wr   = req_write_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/bis_queue.sv =====
// Two-entry queue between the input stage and the chunk splitter.
module bis_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  bis_pkg::req_entry_type   push_entry,
   input  logic                     pop,
   output bis_pkg::queue_status_type q_status,
   output bis_pkg::req_entry_type   head
);
   import bis_pkg::*;

   req_entry_type entries_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign q_status.not_full  = (count_ff != 2'd2);
   assign q_status.not_empty = (count_ff != 2'd0);
   assign do_push = push_valid && q_status.not_full;
   assign do_pop  = pop && q_status.not_empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/bis_back.sv =====
// Chunk splitter: cuts queued requests at bank-word ends, one chunk a cycle unless stalled.
module bis_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bis_pkg::queue_status_type q_status,
   input  bis_pkg::req_entry_type    head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_bank_number,
   output logic [28:0]               rsp_bank_address,
   output logic [3:0]                rsp_chunk_bytes,
   output logic [7:0]                rsp_data_offset,
   output logic                      rsp_chunk_write,
   output logic                      rsp_final_chunk
);
   import bis_pkg::*;

   logic                 busy_ff, busy_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic [DOFF_W-1:0]    done_ff, done_in;
   logic                 wr_ff, wr_in;

   logic                 out_valid_ff, out_valid_in;
   logic [BANK_W-1:0]    out_bank_ff, out_bank_in;
   logic [BADDR_W-1:0]   out_baddr_ff, out_baddr_in;
   logic [CHUNK_W-1:0]   out_len_ff, out_len_in;
   logic [DOFF_W-1:0]    out_doff_ff, out_doff_in;
   logic                 out_wr_ff, out_wr_in;
   logic                 out_final_ff, out_final_in;

   logic [ADDR_BITS-1:0] src_addr;
   logic [LEN_W-1:0]     src_left;
   logic [DOFF_W-1:0]    src_done;
   logic                 src_wr;
   logic                 have_work, fire, fits;
   logic [CHUNK_W-1:0]   room, len;

   // The current request's working registers, or the queue head when idle.
   assign src_addr  = busy_ff ? addr_ff : head.addr;
   assign src_left  = busy_ff ? left_ff : head.len;
   assign src_done  = busy_ff ? done_ff : '0;
   assign src_wr    = busy_ff ? wr_ff   : head.wr;
   assign have_work = busy_ff || q_status.not_empty;
   assign fire      = have_work && (!out_valid_ff || rsp_ready);
   assign pop       = fire && !busy_ff;

   assign room = CHUNK_W'(BANK_BYTES) - CHUNK_W'(src_addr[WORD_SHIFT-1:0]);
   assign fits = (src_left <= LEN_W'(room));
   assign len  = fits ? CHUNK_W'(src_left) : room;

   always_comb begin
      busy_in      = busy_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      done_in      = done_ff;
      wr_in        = wr_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_bank_in  = out_bank_ff;
      out_baddr_in = out_baddr_ff;
      out_len_in   = out_len_ff;
      out_doff_in  = out_doff_ff;
      out_wr_in    = out_wr_ff;
      out_final_in = out_final_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_bank_in  = src_addr[TOP_SHIFT-1:WORD_SHIFT];
         out_baddr_in = BADDR_W'({src_addr[ADDR_BITS-1:TOP_SHIFT],
                                  src_addr[WORD_SHIFT-1:0]});
         out_len_in   = len;
         out_doff_in  = src_done;
         out_wr_in    = src_wr;
         out_final_in = fits;
         busy_in      = !fits;
         addr_in      = src_addr + ADDR_BITS'(len);
         left_in      = src_left - LEN_W'(len);
         done_in      = src_done + DOFF_W'(len);
         wr_in        = src_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      done_ff      <= done_in;
      wr_ff        <= wr_in;
      out_bank_ff  <= out_bank_in;
      out_baddr_ff <= out_baddr_in;
      out_len_ff   <= out_len_in;
      out_doff_ff  <= out_doff_in;
      out_wr_ff    <= out_wr_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_bank_number  = out_bank_ff;
   assign rsp_bank_address = out_baddr_ff;
   assign rsp_chunk_bytes  = out_len_ff;
   assign rsp_data_offset  = out_doff_ff;
   assign rsp_chunk_write  = out_wr_ff;
   assign rsp_final_chunk  = out_final_ff;

endmodule

// ===== rtl/bank_interleave_splitter_unit.sv =====
// Top level of the bank interleave splitter.
// Each request word is cut at 8-byte bank-word boundaries across 8 interleaved banks
// and leaves as one response word per chunk, in ascending address order, the last
// one flagged. The chunk splitter issues one chunk per cycle while rsp_ready does
// not stall its output register, and a request yields at most 33 chunks; a
// zero-length request is accepted and produces nothing. The input register and a
// two-entry queue let requests keep arriving while the splitter works, and the
// first chunk passes through the input register, a queue entry and the splitter's
// output register before it is presented. Lengths above 256 bytes are clamped to
// 256, and addresses wrap at the top of the 32-bit space.
`include "assert_macros.svh"

module bank_interleave_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_start_address,
   input  logic [8:0]  req_request_bytes,
   input  logic        req_write_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bank_number,
   output logic [28:0] rsp_bank_address,
   output logic [3:0]  rsp_chunk_bytes,
   output logic [7:0]  rsp_data_offset,
   output logic        rsp_chunk_write,
   output logic        rsp_final_chunk
);
   import bis_pkg::*;

   queue_status_type q_status;
   req_entry_type    push_entry, head;
   logic             push_valid, pop;

   bis_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_address (req_start_address),
      .req_request_bytes (req_request_bytes),
      .req_write_flag    (req_write_flag),
      .q_status          (q_status),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   bis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .q_status   (q_status),
      .head       (head)
   );

   bis_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bank_number  (rsp_bank_number),
      .rsp_bank_address (rsp_bank_address),
      .rsp_chunk_bytes  (rsp_chunk_bytes),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_chunk_write  (rsp_chunk_write),
      .rsp_final_chunk  (rsp_final_chunk)
   );

   // A chunk that is not the last must run exactly to the end of its bank word.
   `ASSERT_ALWAYS(a_word_end, clock, reset,
      !rsp_valid || rsp_final_chunk ||
      ((CHUNK_W'(rsp_bank_address[WORD_SHIFT-1:0]) + rsp_chunk_bytes) == CHUNK_W'(BANK_BYTES)),
      "non-final chunk does not end at a bank-word boundary")
   // Chunk lengths stay within one bank word.
   `ASSERT_ALWAYS(a_chunk_len, clock, reset,
      !rsp_valid || ((rsp_chunk_bytes != '0) && (rsp_chunk_bytes <= CHUNK_W'(BANK_BYTES))),
      "chunk length out of range")
   // The splitter follows a taken non-final chunk with the next one at once.
   `ASSERT_NEXT(a_next_chunk, clock, reset,
      rsp_valid && rsp_ready && !rsp_final_chunk,
      rsp_valid && (rsp_data_offset ==
                    DOFF_W'($past(rsp_data_offset) + DOFF_W'($past(rsp_chunk_bytes)))),
      "next chunk missing or data offset not contiguous")

endmodule
